[src/battery_thermal_risk_monitor_assert.svh]
// Assertion helpers for the battery thermal risk monitor checker.
`ifndef BATTERY_THERMAL_RISK_MONITOR_ASSERT_SVH
`define BATTERY_THERMAL_RISK_MONITOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BTRM_ASSERT_IMP(label, ck, rstn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("btrm: implication check failed");

// Next-cycle implication, disabled while reset is held.
`define BTRM_ASSERT_NEXT(label, ck, rstn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("btrm: next-cycle check failed");

`endif

[src/btrm_pkg.sv]
package btrm_pkg;

  localparam int TEMP_W     = 12;
  localparam int CUR_W      = 19;
  localparam int ABS_CUR_W  = 19;
  localparam int TIME_W     = 32;
  localparam int RATE_W     = 24;
  localparam int SCORE_W    = 17;
  localparam int ACC_W      = 19;
  localparam int WEIGHT_W   = 7;
  localparam int NORM_W     = 11;
  localparam int MUL_W      = 16;
  localparam int MAG_W      = 28;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 48;

  // Output tdata bit positions
  localparam int RATE_LSB  = 0;
  localparam int OT_BIT    = 24;
  localparam int OC_BIT    = 25;
  localparam int FR_BIT    = 26;
  localparam int SCORE_LSB = 27;
  localparam int ALERT_BIT = 44;

  // Shared serial divider
  localparam int DIV_QW = 28;
  localparam int DIV_RW = 32;
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] RATE_STEPS = 5'd28;
  localparam logic [STEP_W-1:0] NORM_STEPS = 5'd10;

  localparam logic [NORM_W-1:0]  NORM_ONE     = 11'd1024;
  localparam logic [MUL_W-1:0]   RATE_MUL     = 16'd60000;
  localparam logic [SCORE_W-1:0] SCORE_MAX    = 17'd102400;
  localparam logic [RATE_W-1:0]  RATE_POS_MAX = 24'h7FFFFF;
  localparam logic [RATE_W-1:0]  RATE_NEG_MIN = 24'h800000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_WARN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_WARN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_WARN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_FS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_FS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_FS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALERT_LEVEL  = 3'd6;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[src/btrm_div.sv]
module btrm_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  btrm_pkg::div_cmd_t              cmd,
  input  logic [btrm_pkg::DIV_QW-1:0]     dividend,
  input  logic [btrm_pkg::DIV_RW-1:0]     rem_init,
  input  logic [btrm_pkg::DIV_RW-1:0]     divisor,
  output btrm_pkg::div_sts_t              sts,
  output logic [btrm_pkg::DIV_QW-1:0]     quotient
);
  import btrm_pkg::*;

  logic [DIV_RW-1:0] rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic [DIV_QW-1:0] dvd_r, dvd_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [DIV_RW+1:0] trial;
  logic              ge;

  // One restoring step a cycle: shift the next dividend bit into the
  // remainder, subtract when it fits, shift the quotient bit in behind.
  always_comb begin
    trial = {1'b0, rem_r, dvd_r[DIV_QW-1]} - {2'b00, dsr_r};
    ge    = ~trial[DIV_RW+1];

    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (cmd.start) begin
      rem_nxt  = rem_init;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = cmd.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? trial[DIV_RW-1:0] : {rem_r[DIV_RW-2:0], dvd_r[DIV_QW-1]};
      dvd_nxt = {dvd_r[DIV_QW-2:0], ge};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = dvd_r;

endmodule

[src/battery_thermal_risk_monitor.sv]
// Battery thermal risk monitor. Each input transfer is one sample: temperature in 1/16 degC
// (with a present flag on tuser), signed pack current in mA and a millisecond timestamp. Each
// sample yields exactly one result transfer holding the heating rate (1/16 degC per minute,
// saturated to 24 bits), the over-temperature, over-current and fast-rise flags, the weighted
// risk score (1/1024 point, 0..102400) and the alert flag. Samples are handled one at a time:
// the next sample is not taken until the current one has left the state machine. The time a
// sample takes is set by the single bit-serial divider, which runs 28 steps for the heating
// rate and 10 steps for each score term that is not settled at once. A
// finished result sits in the output register, so the next sample is taken while it waits.
// Configuration writes are always ready and are meant to happen while no sample is in flight.
module battery_thermal_risk_monitor #(
  parameter int WEIGHT_TEMP    = 40,
  parameter int WEIGHT_CURRENT = 30,
  parameter int WEIGHT_RISE    = 30
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Sample channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [11:0] temperature, [30:12] current_ma, [62:31] time_ms, [63] zero
  input  logic [btrm_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] temperature_valid
  input  logic                                 in_tuser,
  // Result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [23:0] rise_rate, [24] over_temperature, [25] over_current, [26] fast_rise,
  // [43:27] risk_score, [44] alert, [47:45] zero
  output logic [btrm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // Configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [btrm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [btrm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import btrm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PREP   = 7'b0000010,
    S_RSTART = 7'b0000100,
    S_RWAIT  = 7'b0001000,
    S_NSEL   = 7'b0010000,
    S_NWAIT  = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  // Score term order
  localparam logic [1:0] TERM_TEMP    = 2'd0;
  localparam logic [1:0] TERM_CURRENT = 2'd1;
  localparam logic [1:0] TERM_RISE    = 2'd2;

  localparam logic [WEIGHT_W-1:0] W_TEMP    = WEIGHT_W'(WEIGHT_TEMP);
  localparam logic [WEIGHT_W-1:0] W_CURRENT = WEIGHT_W'(WEIGHT_CURRENT);
  localparam logic [WEIGHT_W-1:0] W_RISE    = WEIGHT_W'(WEIGHT_RISE);

  state_t state_r, state_nxt;

  // Configuration registers
  logic signed [TEMP_W-1:0] temp_warn_r;
  logic [17:0]              cur_warn_r;
  logic [15:0]              rise_warn_r;
  logic [10:0]              temp_fs_r;
  logic [17:0]              cur_fs_r;
  logic [15:0]              rise_fs_r;
  logic [SCORE_W-1:0]       alert_lvl_r;

  // Captured sample
  logic signed [TEMP_W-1:0] temp_r, temp_nxt;
  logic                     valid_r, valid_nxt;
  logic signed [CUR_W-1:0]  cur_r, cur_nxt;
  logic [TIME_W-1:0]        time_r, time_nxt;

  // History
  logic signed [TEMP_W-1:0] last_temp_r, last_temp_nxt;
  logic [TIME_W-1:0]        last_time_r, last_time_nxt;
  logic                     have_last_r, have_last_nxt;

  // Working values
  logic [MAG_W-1:0]         mag_r, mag_nxt;
  logic                     neg_r, neg_nxt;
  logic                     go_r, go_nxt;
  logic [TIME_W-1:0]        delta_r, delta_nxt;
  logic [ABS_CUR_W-1:0]     abs_cur_r, abs_cur_nxt;
  logic                     ot_r, ot_nxt;
  logic                     oc_r, oc_nxt;
  logic signed [RATE_W-1:0] rate_r, rate_nxt;
  logic [1:0]               idx_r, idx_nxt;
  logic [ACC_W-1:0]         score_r, score_nxt;

  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]   out_tdata_r, out_tdata_nxt;

  // Combinational helpers
  logic signed [TEMP_W:0]   diff;
  logic [TEMP_W-1:0]        abs_diff;
  logic signed [RATE_W:0]   nv;
  logic [17:0]              ns;
  logic [WEIGHT_W-1:0]      wsel;
  logic [NORM_W-1:0]        term_val;
  logic                     acc_en;
  logic [17:0]              prod;
  logic [SCORE_W-1:0]       score_sat;
  logic                     fr;
  logic                     alert;

  div_cmd_t                 div_cmd;
  div_sts_t                 div_sts;
  logic [DIV_QW-1:0]        div_dvd;
  logic [DIV_RW-1:0]        div_rem;
  logic [DIV_RW-1:0]        div_dsr;
  logic [DIV_QW-1:0]        div_quot;

  btrm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .dividend (div_dvd),
    .rem_init (div_rem),
    .divisor  (div_dsr),
    .sts      (div_sts),
    .quotient (div_quot)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Temperature step against the last valid reading, and its magnitude.
  assign diff     = {temp_r[TEMP_W-1], temp_r} - {last_temp_r[TEMP_W-1], last_temp_r};
  assign abs_diff = diff[TEMP_W] ? TEMP_W'(-diff) : diff[TEMP_W-1:0];

  // Value, full scale and weight of the score term in hand.
  always_comb begin
    unique case (idx_r)
      TERM_TEMP: begin
        nv   = valid_r ? {{(RATE_W+1-TEMP_W){temp_r[TEMP_W-1]}}, temp_r} : '0;
        ns   = {7'b0, temp_fs_r};
        wsel = W_TEMP;
      end
      TERM_CURRENT: begin
        nv   = {{(RATE_W+1-ABS_CUR_W){1'b0}}, abs_cur_r};
        ns   = cur_fs_r;
        wsel = W_CURRENT;
      end
      TERM_RISE: begin
        nv   = {rate_r[RATE_W-1], rate_r};
        ns   = {2'b0, rise_fs_r};
        wsel = W_RISE;
      end
      default: begin
        nv   = '0;
        ns   = '0;
        wsel = '0;
      end
    endcase
  end

  // Final flags from the finished score and heating rate.
  assign score_sat = (score_r > {2'b00, SCORE_MAX}) ? SCORE_MAX : score_r[SCORE_W-1:0];
  assign fr        = rate_r > $signed({8'b0, rise_warn_r});
  assign alert     = ot_r | oc_r | fr | (score_sat >= alert_lvl_r);
  assign prod      = 18'(wsel) * 18'(term_val);

  always_comb begin
    state_nxt      = state_r;
    temp_nxt       = temp_r;
    valid_nxt      = valid_r;
    cur_nxt        = cur_r;
    time_nxt       = time_r;
    last_temp_nxt  = last_temp_r;
    last_time_nxt  = last_time_r;
    have_last_nxt  = have_last_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    go_nxt         = go_r;
    delta_nxt      = delta_r;
    abs_cur_nxt    = abs_cur_r;
    ot_nxt         = ot_r;
    oc_nxt         = oc_r;
    rate_nxt       = rate_r;
    idx_nxt        = idx_r;
    score_nxt      = score_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    div_cmd        = '0;
    div_dvd        = '0;
    div_rem        = '0;
    div_dsr        = '0;
    acc_en         = 1'b0;
    term_val       = '0;

    // Drop the result once the sink has taken it.
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        // Hold the sample fields for the whole computation.
        if (in_tvalid) begin
          temp_nxt  = in_tdata[11:0];
          cur_nxt   = in_tdata[30:12];
          time_nxt  = in_tdata[62:31];
          valid_nxt = in_tuser;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        // Scale the temperature step, take the time gap, then advance the history.
        mag_nxt     = {{(MAG_W-TEMP_W){1'b0}}, abs_diff} * {{(MAG_W-MUL_W){1'b0}}, RATE_MUL};
        neg_nxt     = diff[TEMP_W];
        go_nxt      = valid_r && have_last_r && (time_r > last_time_r);
        delta_nxt   = time_r - last_time_r;
        abs_cur_nxt = cur_r[CUR_W-1] ? ABS_CUR_W'(-cur_r) : ABS_CUR_W'(cur_r);
        ot_nxt      = valid_r && (temp_r > temp_warn_r);
        oc_nxt      = (cur_r[CUR_W-1] ? ABS_CUR_W'(-cur_r) : ABS_CUR_W'(cur_r))
                      > {1'b0, cur_warn_r};
        if (valid_r) begin
          last_temp_nxt = temp_r;
          last_time_nxt = time_r;
          have_last_nxt = 1'b1;
        end
        state_nxt = S_RSTART;
      end
      S_RSTART: begin
        score_nxt = '0;
        idx_nxt   = TERM_TEMP;
        rate_nxt  = '0;
        if (go_r) begin
          div_cmd.start = 1'b1;
          div_cmd.steps = RATE_STEPS;
          div_dvd       = mag_r;
          div_dsr       = delta_r;
          state_nxt     = S_RWAIT;
        end else begin
          state_nxt = S_NSEL;
        end
      end
      S_RWAIT: begin
        // Saturate the truncated quotient to the signed 24-bit range.
        if (div_sts.done) begin
          if (neg_r) begin
            rate_nxt = (div_quot > {4'b0, RATE_NEG_MIN}) ? RATE_NEG_MIN
                                                       : '0 - div_quot[RATE_W-1:0];
          end else begin
            rate_nxt = (div_quot > {4'b0, RATE_POS_MAX}) ? RATE_POS_MAX
                                                       : div_quot[RATE_W-1:0];
          end
          state_nxt = S_NSEL;
        end
      end
      S_NSEL: begin
        // Settle the easy cases at once; otherwise the value is below full scale
        // and ten fractional steps give the term.
        if (nv[RATE_W] || (nv == '0)) begin
          acc_en   = 1'b1;
          term_val = '0;
        end else if (nv >= $signed({7'b0, ns})) begin
          acc_en   = 1'b1;
          term_val = NORM_ONE;
        end else begin
          div_cmd.start = 1'b1;
          div_cmd.steps = NORM_STEPS;
          div_rem       = {{(DIV_RW-RATE_W){1'b0}}, nv[RATE_W-1:0]};
          div_dsr       = {{(DIV_RW-18){1'b0}}, ns};
          state_nxt     = S_NWAIT;
        end
      end
      S_NWAIT: begin
        if (div_sts.done) begin
          acc_en   = 1'b1;
          term_val = {1'b0, div_quot[NORM_W-2:0]};
        end
      end
      S_FIN: begin
        // Load the output register when it is free or being emptied.
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {3'b000, alert, score_sat, fr, oc_r, ot_r, rate_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Add the weighted term and advance to the next one.
    if (acc_en) begin
      score_nxt = score_r + {1'b0, prod};
      if (idx_r == TERM_RISE) begin
        state_nxt = S_FIN;
      end else begin
        idx_nxt   = idx_r + 2'd1;
        state_nxt = S_NSEL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      last_temp_r  <= '0;
      last_time_r  <= '0;
      have_last_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_temp_r  <= last_temp_nxt;
      last_time_r  <= last_time_nxt;
      have_last_r  <= have_last_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    temp_r      <= temp_nxt;
    valid_r     <= valid_nxt;
    cur_r       <= cur_nxt;
    time_r      <= time_nxt;
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    go_r        <= go_nxt;
    delta_r     <= delta_nxt;
    abs_cur_r   <= abs_cur_nxt;
    ot_r        <= ot_nxt;
    oc_r        <= oc_nxt;
    rate_r      <= rate_nxt;
    idx_r       <= idx_nxt;
    score_r     <= score_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // Configuration: keep the low bits of each write, ignore unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_warn_r <= 12'sd960;
      cur_warn_r  <= 18'd30000;
      rise_warn_r <= 16'd32;
      temp_fs_r   <= 11'd1280;
      cur_fs_r    <= 18'd50000;
      rise_fs_r   <= 16'd160;
      alert_lvl_r <= 17'd71680;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEMP_WARN:    temp_warn_r <= cfg_data[TEMP_W-1:0];
        REG_CURRENT_WARN: cur_warn_r  <= cfg_data[17:0];
        REG_RISE_WARN:    rise_warn_r <= cfg_data[15:0];
        REG_TEMP_FS:      temp_fs_r   <= cfg_data[10:0];
        REG_CURRENT_FS:   cur_fs_r    <= cfg_data[17:0];
        REG_RISE_FS:      rise_fs_r   <= cfg_data[15:0];
        REG_ALERT_LEVEL:  alert_lvl_r <= cfg_data[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[src/btrm_chk.sv]
`include "battery_thermal_risk_monitor_assert.svh"

module btrm_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [btrm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import btrm_pkg::*;

  logic [RATE_W-1:0]  rate_w;
  logic [SCORE_W-1:0] score_w;
  logic               any_flag;

  assign rate_w   = out_tdata[RATE_LSB +: RATE_W];
  assign score_w  = out_tdata[SCORE_LSB +: SCORE_W];
  assign any_flag = out_tdata[OT_BIT] | out_tdata[OC_BIT] | out_tdata[FR_BIT];

  `BTRM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `BTRM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `BTRM_ASSERT_IMP(a_flag_alert, clk, rst_n, out_tvalid && any_flag, out_tdata[ALERT_BIT])
  `BTRM_ASSERT_IMP(a_score_range, clk, rst_n, out_tvalid, score_w <= SCORE_MAX)
  `BTRM_ASSERT_IMP(a_rise_positive, clk, rst_n, out_tvalid && out_tdata[FR_BIT], !rate_w[RATE_W-1] && (rate_w != '0))

endmodule

bind battery_thermal_risk_monitor btrm_chk u_btrm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
